@@ hw/rtl/ppfu_pkg.sv @@
// ppfu_pkg.sv: shared types and constants of the pressure projection face update unit
`timescale 1ns / 1ps

package ppfu_pkg;

    // fixed-point widths
    localparam int unsigned WORD_W      = 32;
    localparam int unsigned FRAC_W      = 16;
    localparam int unsigned KIND_W      = 2;
    localparam int unsigned CFG_INDEX_W = 3;

    // axis codes
    localparam logic CMD_X = 1'b0;
    localparam logic CMD_Y = 1'b1;

    // cell kinds
    localparam logic [KIND_W-1:0] KIND_LIQUID    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_AIR       = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SOLID     = 2'd2;
    localparam logic [KIND_W-1:0] KIND_DIRICHLET = 2'd3;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_GRADIENT_GAIN       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_INFLOW_LEFT_SPEED   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_INFLOW_RIGHT_SPEED  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_INFLOW_TOP_SPEED    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_INFLOW_BOTTOM_SPEED = 3'd4;

    // register reset values
    localparam logic [WORD_W-1:0] GAIN_RESET = 32'h0001_0000;

    // saturation limits
    localparam logic [WORD_W-1:0] SPEED_MAX = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] SPEED_MIN = 32'h8000_0000;

    // one face item
    typedef struct packed {
        logic                     cmd;
        logic [KIND_W-1:0]        cell_kind;
        logic [KIND_W-1:0]        next_cell_kind;
        logic                     first_face;
        logic                     last_face;
        logic signed [WORD_W-1:0] face_speed;
        logic signed [WORD_W-1:0] pressure_here;
        logic signed [WORD_W-1:0] pressure_next;
        logic signed [WORD_W-1:0] pressure_prev;
    } face_in_t;

    // one result item
    typedef struct packed {
        logic signed [WORD_W-1:0] new_speed;
        logic                     saturated;
    } face_out_t;

endpackage

@@ hw/rtl/pressure_projection_face_update_unit.sv @@
// pressure_projection_face_update_unit.sv: top level, projects one velocity face per item
//
//  channel   direction  handshake                    payload
//  cfg       in         cfg_write                    cfg_index, cfg_data
//  face      in         face_valid / face_stall      face (ppfu_pkg::face_in_t)
//  result    out        result_valid / result_stall  result (ppfu_pkg::face_out_t)
//
// one face item per cycle while the result channel is not stalled; an accepted item passes the face
// input register and then the result register, where it is offered. stage one is the face input
// register, stage two the result register; the multiply by the gain, rounding, subtract and saturation sit between them
// rst_n clears the valid bits asynchronously and loads the register reset values
// a stalled result holds; stage one keeps taking items until it also holds one
`timescale 1ns / 1ps

module pressure_projection_face_update_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [ppfu_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [ppfu_pkg::WORD_W-1:0]           cfg_data,
    input  logic                                  face_valid,
    output logic                                  face_stall,
    input  ppfu_pkg::face_in_t                    face,
    output logic                                  result_valid,
    input  logic                                  result_stall,
    output ppfu_pkg::face_out_t                   result
);

    import ppfu_pkg::*;

    localparam int unsigned DIFF_W = WORD_W + 1;
    localparam int unsigned PROD_W = 2 * DIFF_W;
    localparam int unsigned TERM_W = PROD_W - FRAC_W;
    localparam int unsigned SUM_W  = TERM_W + 1;

    // configuration registers
    logic [WORD_W-1:0] gain_reg;
    logic [WORD_W-1:0] left_speed_reg;
    logic [WORD_W-1:0] right_speed_reg;
    logic [WORD_W-1:0] top_speed_reg;
    logic [WORD_W-1:0] bottom_speed_reg;

    // pipeline registers
    logic      s1_valid_reg;
    logic      s1_valid_next;
    face_in_t  s1_face_reg;
    logic      result_valid_reg;
    logic      result_valid_next;
    face_out_t result_reg;
    face_out_t result_next;

    logic face_accept;
    logic out_ready;
    logic s1_advance;

    // datapath
    logic                     solid_face;
    logic signed [DIFF_W-1:0] diff;
    logic signed [DIFF_W-1:0] gain_ext;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] round_bias;
    logic signed [PROD_W-1:0] rounded;
    logic signed [TERM_W-1:0] term;
    logic signed [SUM_W-1:0]  sum;
    logic                     sat_hi;
    logic                     sat_lo;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg         <= GAIN_RESET;
            left_speed_reg   <= '0;
            right_speed_reg  <= '0;
            top_speed_reg    <= '0;
            bottom_speed_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_GRADIENT_GAIN:       gain_reg         <= cfg_data;
                CFG_INFLOW_LEFT_SPEED:   left_speed_reg   <= cfg_data;
                CFG_INFLOW_RIGHT_SPEED:  right_speed_reg  <= cfg_data;
                CFG_INFLOW_TOP_SPEED:    top_speed_reg    <= cfg_data;
                CFG_INFLOW_BOTTOM_SPEED: bottom_speed_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // handshake
    assign out_ready         = !result_valid_reg || !result_stall;
    assign s1_advance        = s1_valid_reg && out_ready;
    assign face_stall        = s1_valid_reg && !out_ready;
    assign face_accept       = face_valid && !face_stall;
    assign s1_valid_next     = face_accept || (s1_valid_reg && !s1_advance);
    assign result_valid_next = out_ready ? s1_valid_reg : result_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg     <= s1_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (face_accept)
        begin
            s1_face_reg <= face;
        end
        if (s1_advance)
        begin
            result_reg <= result_next;
        end
    end

    // pressure gradient term, rounded to nearest with ties away from zero
    always_comb
    begin
        if (s1_face_reg.last_face)
        begin
            diff = {s1_face_reg.pressure_here[WORD_W-1], s1_face_reg.pressure_here}
                 - {s1_face_reg.pressure_prev[WORD_W-1], s1_face_reg.pressure_prev};
        end
        else
        begin
            diff = {s1_face_reg.pressure_next[WORD_W-1], s1_face_reg.pressure_next}
                 - {s1_face_reg.pressure_here[WORD_W-1], s1_face_reg.pressure_here};
        end
        gain_ext   = {1'b0, gain_reg};
        prod       = diff * gain_ext;
        round_bias = prod[PROD_W-1] ? PROD_W'((1 << (FRAC_W - 1)) - 1)
                                    : PROD_W'(1 << (FRAC_W - 1));
        rounded    = prod + round_bias;
        term       = rounded[PROD_W-1:FRAC_W];
        sum        = {{(SUM_W - WORD_W){s1_face_reg.face_speed[WORD_W-1]}},
                      s1_face_reg.face_speed}
                   - {term[TERM_W-1], term};
        sat_hi     = !sum[SUM_W-1] && (|sum[SUM_W-2:WORD_W-1]);
        sat_lo     = sum[SUM_W-1] && !(&sum[SUM_W-2:WORD_W-1]);
    end

    // face kind selection
    always_comb
    begin
        solid_face = (s1_face_reg.cell_kind == KIND_SOLID)
                  || (!s1_face_reg.last_face && s1_face_reg.next_cell_kind == KIND_SOLID);
        result_next.new_speed = '0;
        result_next.saturated = 1'b0;
        if (solid_face)
        begin
            result_next.new_speed = '0;
        end
        else if (s1_face_reg.cell_kind == KIND_DIRICHLET)
        begin
            // last face wins when both flags are set
            if (s1_face_reg.last_face)
            begin
                result_next.new_speed = (s1_face_reg.cmd == CMD_Y) ? top_speed_reg
                                                                   : right_speed_reg;
            end
            else if (s1_face_reg.first_face)
            begin
                result_next.new_speed = (s1_face_reg.cmd == CMD_Y) ? bottom_speed_reg
                                                                   : left_speed_reg;
            end
        end
        else if (sat_hi)
        begin
            result_next.new_speed = SPEED_MAX;
            result_next.saturated = 1'b1;
        end
        else if (sat_lo)
        begin
            result_next.new_speed = SPEED_MIN;
            result_next.saturated = 1'b1;
        end
        else
        begin
            result_next.new_speed = sum[WORD_W-1:0];
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

@@ hw/rtl/ppfu_checker.sv @@
// ppfu_checker.sv: port-level assertions for the face update unit and their bind
`timescale 1ns / 1ps

module ppfu_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                face_valid,
    input logic                face_stall,
    input ppfu_pkg::face_in_t  face,
    input logic                result_valid,
    input logic                result_stall,
    input ppfu_pkg::face_out_t result
);

    import ppfu_pkg::*;

    // no result item shows while in reset
    a_no_result_in_reset: assert property (@(posedge clk)
        !rst_n |-> !result_valid)
        else $error("result valid during reset");

    // a stalled result item stays offered
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result item changed");

    // input only stalls when both stages are full and the output is stalled
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        face_stall |-> result_valid && result_stall)
        else $error("face stall without a stalled result");

    // a clipped result sits on one of the range limits
    a_sat_limits: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.saturated |->
            (result.new_speed == SPEED_MAX) || (result.new_speed == SPEED_MIN))
        else $error("saturated result off the range limits");

    // with the output free, an accepted solid-cell item is offered as zero once it has passed both stages
    a_solid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        face_valid && !face_stall && face.cell_kind == KIND_SOLID && !result_stall
            ##1 !result_stall |=> result_valid && result.new_speed == '0
            && !result.saturated)
        else $error("solid face not zeroed");

endmodule

bind pressure_projection_face_update_unit ppfu_checker u_ppfu_checker (.*);

@@ tb/ppfu_checker.sv @@
// ppfu_checker.sv: watches the face and result channels, predicts each face update and compares
`timescale 1ns / 1ps

module ppfu_scoreboard (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [ppfu_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ppfu_pkg::WORD_W-1:0]      cfg_data,
    input  logic                             face_valid,
    input  logic                             face_stall,
    input  ppfu_pkg::face_in_t               face,
    input  logic                             result_valid,
    input  logic                             result_stall,
    input  ppfu_pkg::face_out_t              result,
    output int                               fail_count,
    output int                               expected_left
);

    import ppfu_pkg::*;

    localparam longint SPEED_HI = longint'($signed(SPEED_MAX));
    localparam longint SPEED_LO = longint'($signed(SPEED_MIN));

    // shadow copy of the block's registers
    logic [WORD_W-1:0]        gain_q;
    logic signed [WORD_W-1:0] left_q;
    logic signed [WORD_W-1:0] right_q;
    logic signed [WORD_W-1:0] top_q;
    logic signed [WORD_W-1:0] bottom_q;

    face_out_t projected_speeds[$];
    int        fails;

    // projected speed of one face under the current register values
    function automatic face_out_t project_face(input face_in_t f);
        face_out_t        r;
        longint           diff;
        longint           term;
        longint           sum;
        longint unsigned  mag;
        longint unsigned  prod;
        r.new_speed = '0;
        r.saturated = 1'b0;
        if (f.cell_kind == KIND_SOLID || (!f.last_face && f.next_cell_kind == KIND_SOLID))
        begin
            r.new_speed = '0;
        end
        else if (f.cell_kind == KIND_DIRICHLET)
        begin
            // last face wins when both flags are set
            if (f.first_face)
                r.new_speed = (f.cmd == CMD_Y) ? bottom_q : left_q;
            if (f.last_face)
                r.new_speed = (f.cmd == CMD_Y) ? top_q : right_q;
        end
        else
        begin
            // backward difference on the last face, forward otherwise
            if (f.last_face)
                diff = longint'(f.pressure_here) - longint'(f.pressure_prev);
            else
                diff = longint'(f.pressure_next) - longint'(f.pressure_here);
            mag  = (diff < 0) ? longint'(-diff) : diff;
            prod = mag * {32'd0, gain_q};
            // round half away from zero on the magnitude
            term = longint'((prod + 64'h8000) >> FRAC_W);
            if (diff < 0)
                term = -term;
            sum = longint'(f.face_speed) - term;
            if (sum > SPEED_HI)
            begin
                sum         = SPEED_HI;
                r.saturated = 1'b1;
            end
            else if (sum < SPEED_LO)
            begin
                sum         = SPEED_LO;
                r.saturated = 1'b1;
            end
            r.new_speed = sum[WORD_W-1:0];
        end
        return r;
    endfunction

    // register shadow, prediction and comparison
    always @(posedge clk or negedge rst_n)
    begin
        face_out_t want;
        if (!rst_n)
        begin
            gain_q   = GAIN_RESET;
            left_q   = '0;
            right_q  = '0;
            top_q    = '0;
            bottom_q = '0;
            projected_speeds.delete();
            fails = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_GRADIENT_GAIN:       gain_q   = cfg_data;
                    CFG_INFLOW_LEFT_SPEED:   left_q   = cfg_data;
                    CFG_INFLOW_RIGHT_SPEED:  right_q  = cfg_data;
                    CFG_INFLOW_TOP_SPEED:    top_q    = cfg_data;
                    CFG_INFLOW_BOTTOM_SPEED: bottom_q = cfg_data;
                    default: ;
                endcase
            end
            // compare an accepted result with the oldest prediction
            if (result_valid && !result_stall)
            begin
                if (projected_speeds.size() == 0)
                begin
                    $error("result item with no face item pending: new_speed %0d saturated %0b",
                           result.new_speed, result.saturated);
                    fails++;
                end
                else
                begin
                    want = projected_speeds.pop_front();
                    if (result.new_speed !== want.new_speed)
                    begin
                        $error("new_speed mismatch: expected %0d, actual %0d",
                               want.new_speed, result.new_speed);
                        fails++;
                    end
                    if (result.saturated !== want.saturated)
                    begin
                        $error("saturated mismatch: expected %0b, actual %0b",
                               want.saturated, result.saturated);
                        fails++;
                    end
                end
            end
            // predict each accepted face item
            if (face_valid && !face_stall)
                projected_speeds.insert(projected_speeds.size(), project_face(face));
        end
        fail_count    <= fails;
        expected_left <= projected_speeds.size();
    end

endmodule

@@ tb/pressure_projection_face_update_unit_tb.sv @@
// pressure_projection_face_update_unit_tb.sv: stimulus, reset and verdict for the face update unit
`timescale 1ns / 1ps

module pressure_projection_face_update_unit_tb;

    import ppfu_pkg::*;

    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 280;
    localparam int HOLD_OFF_CYCLES = 150;
    localparam int SETTLE_CYCLES   = 6;
    localparam int IDLE_LIMIT      = 3000;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [WORD_W-1:0]      cfg_data;
    logic                   face_valid;
    logic                   face_stall;
    face_in_t               face;
    logic                   result_valid;
    logic                   result_stall;
    face_out_t              result;

    int   fail_count;
    int   expected_left;
    int   idle_cycles;
    logic calm;
    logic hold_off_req;

    pressure_projection_face_update_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .face_valid   (face_valid),
        .face_stall   (face_stall),
        .face         (face),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    ppfu_scoreboard u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .face_valid    (face_valid),
        .face_stall    (face_stall),
        .face          (face),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .result        (result),
        .fail_count    (fail_count),
        .expected_left (expected_left)
    );

    // clock
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // watchdog on cycles with no accepted item and no register write
    always @(posedge clk)
    begin
        if (!rst_n || cfg_write || (face_valid && !face_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // result receiver: random stalls, calm stretches and one long hold-off
    initial
    begin
        int unsigned pick;
        result_stall = 1'b0;
        forever
        begin
            pick = $urandom_range(0, 99);
            if (hold_off_req)
            begin
                result_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            else if (calm)
            begin
                result_stall <= 1'b0;
                @(posedge clk);
            end
            else if (pick < 3)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(5, 40)) @(posedge clk);
            end
            else
            begin
                result_stall <= (pick < 30);
                @(posedge clk);
            end
        end
    end

    // gap before the next face item: mostly none or short, a few long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // Q16.16 word: small values, extremes or anything
    function automatic logic [WORD_W-1:0] random_word();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
        if (r < 52)
        begin
            case ($urandom_range(0, 3))
                0:       return SPEED_MAX;
                1:       return SPEED_MIN;
                2:       return 32'h0;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        return $urandom;
    endfunction

    // cell kind weighted toward the pressure path
    function automatic logic [KIND_W-1:0] random_kind();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return KIND_LIQUID;
        if (r < 65)
            return KIND_AIR;
        if (r < 80)
            return KIND_SOLID;
        return KIND_DIRICHLET;
    endfunction

    function automatic face_in_t make_face(
        input logic              cmd_v,
        input logic [KIND_W-1:0] kind_v,
        input logic [KIND_W-1:0] next_v,
        input logic              first_v,
        input logic              last_v,
        input logic [WORD_W-1:0] speed_v,
        input logic [WORD_W-1:0] here_v,
        input logic [WORD_W-1:0] next_p,
        input logic [WORD_W-1:0] prev_p
    );
        face_in_t f;
        f.cmd            = cmd_v;
        f.cell_kind      = kind_v;
        f.next_cell_kind = next_v;
        f.first_face     = first_v;
        f.last_face      = last_v;
        f.face_speed     = speed_v;
        f.pressure_here  = here_v;
        f.pressure_next  = next_p;
        f.pressure_prev  = prev_p;
        return f;
    endfunction

    function automatic face_in_t random_face();
        return make_face($urandom_range(0, 1) ? CMD_Y : CMD_X, random_kind(),
                         ($urandom_range(0, 99) < 15) ? KIND_SOLID : random_kind(),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         random_word(), random_word(), random_word(), random_word());
    endfunction

    // offer one face item and hold it until accepted
    task automatic offer_face(input face_in_t f);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            face_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        face_valid <= 1'b1;
        face       <= f;
        do
            @(posedge clk);
        while (face_stall);
    endtask

    // stop offering and wait until every predicted result has come back
    task automatic drain();
        face_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_left != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [WORD_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic program_regs(
        input logic [WORD_W-1:0] gain_v,
        input logic [WORD_W-1:0] left_v,
        input logic [WORD_W-1:0] right_v,
        input logic [WORD_W-1:0] top_v,
        input logic [WORD_W-1:0] bottom_v
    );
        drain();
        write_reg(CFG_GRADIENT_GAIN, gain_v);
        write_reg(CFG_INFLOW_LEFT_SPEED, left_v);
        write_reg(CFG_INFLOW_RIGHT_SPEED, right_v);
        write_reg(CFG_INFLOW_TOP_SPEED, top_v);
        write_reg(CFG_INFLOW_BOTTOM_SPEED, bottom_v);
        cfg_write <= 1'b0;
    endtask

    // main sequence
    initial
    begin
        rst_n        = 1'b0;
        cfg_write    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        face_valid   = 1'b0;
        face         = '0;
        calm         = 1'b0;
        hold_off_req = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values of gain and inflow speeds
        offer_face(make_face(CMD_X, KIND_LIQUID, KIND_AIR, 1'b0, 1'b0,
                             32'h0005_0000, 32'h0001_0000, 32'h0003_0000, 32'h0));
        offer_face(make_face(CMD_X, KIND_DIRICHLET, KIND_LIQUID, 1'b1, 1'b0,
                             32'h0004_0000, 32'h0, 32'h0, 32'h0));

        // gain 1.5 makes a unit pressure step a rounding tie
        program_regs(32'h0001_8000, 32'h0001_2345, 32'hFFFE_8000, SPEED_MAX, SPEED_MIN);

        // solid cell, and solid next cell away from and at the last face
        offer_face(make_face(CMD_X, KIND_SOLID, KIND_LIQUID, 1'b0, 1'b0,
                             32'h0002_0000, 32'h0001_0000, 32'h0, 32'h0));
        offer_face(make_face(CMD_X, KIND_LIQUID, KIND_SOLID, 1'b0, 1'b0,
                             32'h0002_0000, 32'h0001_0000, 32'h0, 32'h0));
        offer_face(make_face(CMD_X, KIND_LIQUID, KIND_SOLID, 1'b0, 1'b1,
                             32'h0002_0000, 32'h0003_0000, 32'h0007_0000, 32'h0001_0000));
        // dirichlet faces on both axes, every flag combination on x and each set flag on y
        offer_face(make_face(CMD_X, KIND_DIRICHLET, KIND_AIR, 1'b1, 1'b0,
                             32'h1, 32'h0, 32'h0, 32'h0));
        offer_face(make_face(CMD_X, KIND_DIRICHLET, KIND_AIR, 1'b0, 1'b1,
                             32'h1, 32'h0, 32'h0, 32'h0));
        offer_face(make_face(CMD_X, KIND_DIRICHLET, KIND_AIR, 1'b1, 1'b1,
                             32'h1, 32'h0, 32'h0, 32'h0));
        offer_face(make_face(CMD_X, KIND_DIRICHLET, KIND_AIR, 1'b0, 1'b0,
                             32'h1, 32'h0, 32'h0, 32'h0));
        offer_face(make_face(CMD_Y, KIND_DIRICHLET, KIND_LIQUID, 1'b1, 1'b0,
                             32'h1, 32'h0, 32'h0, 32'h0));
        offer_face(make_face(CMD_Y, KIND_DIRICHLET, KIND_LIQUID, 1'b0, 1'b1,
                             32'h1, 32'h0, 32'h0, 32'h0));
        offer_face(make_face(CMD_Y, KIND_DIRICHLET, KIND_LIQUID, 1'b1, 1'b1,
                             32'h1, 32'h0, 32'h0, 32'h0));
        // dirichlet cell beside a solid one is zeroed
        offer_face(make_face(CMD_Y, KIND_DIRICHLET, KIND_SOLID, 1'b1, 1'b0,
                             32'h1, 32'h0, 32'h0, 32'h0));
        // air on y with forward difference, then liquid with both flags and backward difference
        offer_face(make_face(CMD_Y, KIND_AIR, KIND_LIQUID, 1'b0, 1'b0,
                             32'hFFFF_0000, 32'h0002_0000, 32'hFFFF_8000, 32'h0));
        offer_face(make_face(CMD_Y, KIND_LIQUID, KIND_AIR, 1'b1, 1'b1,
                             32'h0000_4000, 32'h0002_0000, 32'h7000_0000, 32'h0003_0000));
        // rounding ties on both signs
        offer_face(make_face(CMD_X, KIND_LIQUID, KIND_LIQUID, 1'b0, 1'b0,
                             32'h0, 32'h0000_0010, 32'h0000_0011, 32'h0));
        offer_face(make_face(CMD_X, KIND_AIR, KIND_LIQUID, 1'b0, 1'b0,
                             32'h0, 32'h0000_0011, 32'h0000_0010, 32'h0));
        // saturation high and low with the widest pressure spans
        offer_face(make_face(CMD_X, KIND_LIQUID, KIND_AIR, 1'b0, 1'b0,
                             SPEED_MAX, SPEED_MAX, SPEED_MIN, SPEED_MAX));
        offer_face(make_face(CMD_Y, KIND_AIR, KIND_AIR, 1'b0, 1'b0,
                             SPEED_MIN, SPEED_MIN, SPEED_MAX, SPEED_MIN));
        offer_face(make_face(CMD_Y, KIND_AIR, KIND_LIQUID, 1'b0, 1'b1,
                             SPEED_MIN, SPEED_MAX, SPEED_MIN, SPEED_MIN));
        offer_face(make_face(CMD_X, KIND_LIQUID, KIND_LIQUID, 1'b1, 1'b0,
                             SPEED_MIN, 32'h0001_0000, 32'h0001_0000, SPEED_MAX));

        // random phases, each under its own register setting
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: program_regs(32'h0001_0000, $urandom, $urandom, $urandom, $urandom);
                1: program_regs(32'h0, SPEED_MAX, SPEED_MIN, 32'h0, 32'hFFFF_FFFF);
                2: program_regs(32'hFFFF_FFFF, SPEED_MIN, SPEED_MAX, SPEED_MIN, SPEED_MAX);
                3: program_regs($urandom_range(1, 32'h0004_0000), $urandom, $urandom,
                                $urandom, $urandom);
                4: program_regs($urandom, $urandom, $urandom, $urandom, $urandom);
                default: program_regs(32'h0000_8000, 32'h0, 32'h0, 32'h0, 32'h0);
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                calm = ((n % 120) < 20);
                // long receiver hold-off while faces keep coming
                if (p == 3 && n == 100)
                    hold_off_req = 1'b1;
                offer_face(random_face());
            end
        end
        calm = 1'b0;
        drain();

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
